>>> design/double_ended_queue_macros.svh
// assertion macros for the double-ended queue
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define DEQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/deq_pkg.sv
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int REQ_W     = 3;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_LIST       = 3'd4
  } req_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_POP,
    S_LIST
  } state_t;

endpackage

>>> design/deq_if.sv
interface deq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic        [deq_pkg::REQ_W-1:0]      req_type;
  logic signed [deq_pkg::DATA_W-1:0]     value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface deq_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [deq_pkg::DATA_W-1:0]     value_res;
  logic        [deq_pkg::STAT_W-1:0]     status;
  logic                                  last;

  modport source (output valid, output value_res, output status, output last, input ready);
  modport sink   (input valid, input value_res, input status, input last, output ready);
endinterface

>>> design/double_ended_queue.sv
// push: result registered (stashed if output busy); one push per cycle while results drain
// pop: result via the registered read of the entry memory, then the output register
// list of n entries: read in order from the front, one entry per cycle while results drain,
//   next request taken after the last entry is handed to the output register
// reset (rst_n low, synchronous) empties the queue at once; entry memory is not cleared
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  deq_req_if.sink    in_ch,
  deq_res_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);

  // memory port signals between controller and ring store
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [deq_pkg::DATA_W-1:0]  wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [deq_pkg::DATA_W-1:0]  rd_data;

  // controller: front pointer, entry count, request decode, list walker and
  // the output register with a one-entry stash for push and empty-store results
  // of an accepted transaction that finds the output still occupied
  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ring store: one write port, one registered read port; read data holds
  // while the output is stalled so nothing is refetched
  deq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // writes and reads never share a cycle, so no same-entry forwarding is needed
  `DEQ_ASSERT_SAME(a_no_rw_overlap, wr_en, !rd_en, "memory written and read in one cycle")
  // the store is only written by an accepted push transaction
  `DEQ_ASSERT_SAME(a_wr_on_accept, wr_en, in_ch.valid && in_ch.ready, "write without accepted push")
  // an error result carries a zero value and closes its request
  `DEQ_ASSERT_SAME(a_err_result, out_ch.valid && (out_ch.status != deq_pkg::ST_OK), (out_ch.value_res == '0) && out_ch.last, "malformed error result")

endmodule

>>> design/deq_store.sv
module deq_store #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [deq_pkg::DATA_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [deq_pkg::DATA_W-1:0]  rd_data
);

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [deq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/deq_ctrl.sv
module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  deq_req_if.sink                     in_ch,
  deq_res_if.source                   out_ch,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [deq_pkg::DATA_W-1:0]  wr_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [deq_pkg::DATA_W-1:0]  rd_data
);

  localparam int SW = CW + 1;

  // ring position of the entry at a given offset from the front
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] front,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(front) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  deq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   front_r, front_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [deq_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  deq_pkg::status_t           out_status_r, out_status_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [deq_pkg::DATA_W-1:0] pend_value_r, pend_value_nxt;
  deq_pkg::status_t           pend_status_r, pend_status_nxt;

  logic             acc, out_free, full, empty;
  logic             is_push, is_pop, is_list, is_front;
  logic             push_go, pop_go, list_go, imm;
  logic             list_last;
  logic [AW-1:0]    front_dec, front_inc;

  assign in_ch.ready = (state_r == deq_pkg::S_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign full        = (count_r == CW'(DEPTH));
  assign empty       = (count_r == '0);

  assign is_push  = (in_ch.req_type == deq_pkg::REQ_PUSH_FRONT) ||
                    (in_ch.req_type == deq_pkg::REQ_PUSH_BACK);
  assign is_pop   = (in_ch.req_type == deq_pkg::REQ_POP_FRONT) ||
                    (in_ch.req_type == deq_pkg::REQ_POP_BACK);
  assign is_list  = (in_ch.req_type == deq_pkg::REQ_LIST);
  assign is_front = (in_ch.req_type == deq_pkg::REQ_PUSH_FRONT) ||
                    (in_ch.req_type == deq_pkg::REQ_POP_FRONT);

  assign push_go = acc && is_push && !full;
  assign pop_go  = acc && is_pop && !empty;
  assign list_go = acc && is_list && !empty;
  // results known at acceptance: pushes, and anything on an empty store
  assign imm     = acc && (is_push || ((is_pop || is_list) && empty));

  assign list_last = ((CW'(idx_r) + CW'(1)) == count_r);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = slot_at(front_r, CW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      deq_pkg::S_IDLE: begin
        if (imm && !out_free) begin
          state_nxt = deq_pkg::S_EMIT;
        end else if (pop_go) begin
          state_nxt = deq_pkg::S_POP;
        end else if (list_go) begin
          state_nxt = deq_pkg::S_LIST;
        end
      end
      deq_pkg::S_EMIT: begin
        if (out_free) state_nxt = deq_pkg::S_IDLE;
      end
      deq_pkg::S_POP: begin
        if (out_free) state_nxt = deq_pkg::S_IDLE;
      end
      deq_pkg::S_LIST: begin
        if (out_free && list_last) state_nxt = deq_pkg::S_IDLE;
      end
      default: state_nxt = deq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = front_dec;
    wr_data         = in_ch.value;
    rd_en           = 1'b0;
    rd_addr         = front_r;
    front_nxt       = front_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_value_nxt   = out_value_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    pend_value_nxt  = pend_value_r;
    pend_status_nxt = pend_status_r;
    case (state_r)
      deq_pkg::S_IDLE: begin
        if (push_go) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
          if (is_front) begin
            wr_addr   = front_dec;
            front_nxt = front_dec;
          end else begin
            wr_addr = slot_at(front_r, count_r);
          end
        end
        if (pop_go) begin
          rd_en     = 1'b1;
          count_nxt = count_r - CW'(1);
          if (is_front) begin
            rd_addr   = front_r;
            front_nxt = front_inc;
          end else begin
            rd_addr = slot_at(front_r, count_r - CW'(1));
          end
        end
        if (list_go) begin
          rd_en   = 1'b1;
          rd_addr = front_r;
          idx_nxt = '0;
        end
        if (imm) begin
          pend_value_nxt  = push_go ? in_ch.value : '0;
          pend_status_nxt = push_go ? deq_pkg::ST_OK :
                            (is_push ? deq_pkg::ST_FULL : deq_pkg::ST_EMPTY);
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = pend_value_nxt;
            out_status_nxt = pend_status_nxt;
            out_last_nxt   = 1'b1;
          end
        end
      end
      deq_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = pend_value_r;
          out_status_nxt = pend_status_r;
          out_last_nxt   = 1'b1;
        end
      end
      deq_pkg::S_POP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_data;
          out_status_nxt = deq_pkg::ST_OK;
          out_last_nxt   = 1'b1;
        end
      end
      deq_pkg::S_LIST: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_data;
          out_status_nxt = deq_pkg::ST_OK;
          out_last_nxt   = list_last;
          if (!list_last) begin
            rd_en   = 1'b1;
            rd_addr = slot_at(front_r, CW'(idx_r) + CW'(1));
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    out_value_r   <= out_value_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
    pend_value_r  <= pend_value_nxt;
    pend_status_r <= pend_status_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_res = out_value_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.last      = out_last_r;

endmodule
